FILE: rtl/bglbp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bglbp_pkg
// Shared widths, register indexes, reset values and the window item type
// for the background LBP 3x3 texture coder.
// ----------------------------------------------------------------------------
package bglbp_pkg;

	localparam int PIX_W         = 8;
	localparam int ROW_W         = 12;
	localparam int COL_W         = 10;
	localparam int BETA_W        = 9;
	localparam int IMG_W_W       = 11;
	localparam int IMG_H_W       = 12;
	localparam int CFG_DATA_W    = 12;
	localparam int CFG_IDX_W     = 2;
	localparam int DIM_EXT_W     = 13;
	localparam int WIN           = 3;
	localparam int WIN_PIX       = WIN * WIN;
	localparam int ROWSUM_W      = 10;
	localparam int SUM_W         = 12;
	localparam int DIFF_W        = 13;
	localparam int MAX_WIDTH_DEF = 1024;
	localparam int QUEUE_DEPTH   = 2;

	localparam logic [CFG_IDX_W-1:0] REG_BETA   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

	localparam logic [BETA_W-1:0]  BETA_RST   = 9'd3;
	localparam logic [IMG_W_W-1:0] WIDTH_RST  = 11'd640;
	localparam logic [IMG_H_W-1:0] HEIGHT_RST = 12'd480;

	typedef struct packed {
		logic [WIN_PIX-1:0][PIX_W-1:0] pix;
		logic [ROW_W-1:0]              row_index;
		logic [COL_W-1:0]              col_index;
		logic                          last_of_frame;
	} item_t;

endpackage
`default_nettype wire

FILE: rtl/background_lbp_3x3_texture_code.sv
`default_nettype none
// ----------------------------------------------------------------------------
// background_lbp_3x3_texture_code
// Background LBP texture coder over a 3x3 window of a raster pixel stream.
// ----------------------------------------------------------------------------
// Input channel: one 8-bit pixel per item, raster order, on in_valid with
// in_stall from this block. Output channel: one item per interior pixel
// (code, row_index, col_index, last_of_frame) on out_valid, held while
// out_stall is high. Border pixels are taken and produce no item.
// Throughput: one pixel per cycle while nothing stalls; the line store is
// a single read and single write port memory touched once per pixel.
// A completing pixel passes the front register, the queue and the pipeline.
// The front, a two-entry queue and the three-stage code pipeline each stall
// on their own; a stalled output fills the pipe and then the queue, and
// in_stall rises only once the front can no longer hand a window on.
// Reset: registers return to beta 3, width 640, height 480; the line store
// is cleared one entry per cycle over all MAX_WIDTH entries, with in_stall
// high all that time. Configuration writes are taken at any time through
// cfg_we, cfg_index and cfg_data; change geometry only while idle.
// ----------------------------------------------------------------------------
module background_lbp_3x3_texture_code #(
	parameter int MAX_WIDTH = bglbp_pkg::MAX_WIDTH_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [bglbp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [bglbp_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [bglbp_pkg::PIX_W-1:0]         pixel,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [bglbp_pkg::PIX_W-1:0]              code,
	output logic [bglbp_pkg::ROW_W-1:0]              row_index,
	output logic [bglbp_pkg::COL_W-1:0]              col_index,
	output logic                                     last_of_frame
);
	import bglbp_pkg::*;

	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam logic [DIM_EXT_W-1:0] MAXW = DIM_EXT_W'(MAX_WIDTH);

	logic [BETA_W-1:0]     beta_q;
	logic [IMG_W_W-1:0]    width_q;
	logic [IMG_H_W-1:0]    height_q;

	logic [DIM_EXT_W-1:0]  w_raw;
	logic [DIM_EXT_W-1:0]  w_clamp;
	logic [WW-1:0]         w_eff;
	logic [ROW_W-1:0]      h_eff;

	logic                  front_ready;
	logic                  fq_valid;
	logic                  fq_ready;
	item_t                 fq_item;
	logic                  qb_valid;
	logic                  qb_ready;
	item_t                 qb_item;
	logic                  clearing;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beta_q   <= BETA_RST;
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BETA:   beta_q   <= cfg_data[BETA_W-1:0];
				REG_WIDTH:  width_q  <= cfg_data[IMG_W_W-1:0];
				REG_HEIGHT: height_q <= cfg_data[IMG_H_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		w_raw = DIM_EXT_W'(width_q);
		if (w_raw < DIM_EXT_W'(3)) begin
			w_clamp = DIM_EXT_W'(3);
		end else if (w_raw > MAXW) begin
			w_clamp = MAXW;
		end else begin
			w_clamp = w_raw;
		end
		w_eff = WW'(w_clamp);
		h_eff = (height_q < IMG_H_W'(3)) ? ROW_W'(3) : ROW_W'(height_q);
	end

	assign in_stall = !front_ready;

	bglbp_front #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.w_eff    (w_eff),
		.h_eff    (h_eff),
		.in_valid (in_valid),
		.in_ready (front_ready),
		.pixel    (pixel),
		.q_valid  (fq_valid),
		.q_ready  (fq_ready),
		.q_item   (fq_item),
		.clearing (clearing)
	);

	bglbp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_item   (fq_item),
		.out_valid (qb_valid),
		.out_ready (qb_ready),
		.out_item  (qb_item)
	);

	bglbp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.beta          (beta_q),
		.in_valid      (qb_valid),
		.in_ready      (qb_ready),
		.in_item       (qb_item),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.code          (code),
		.row_index     (row_index),
		.col_index     (col_index),
		.last_of_frame (last_of_frame)
	);

	a_no_output_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !out_valid)
		else $error("result presented during line store clear");

	a_last_at_frame_corner: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_of_frame) |->
		(row_index == ROW_W'(h_eff - ROW_W'(2)) && col_index == COL_W'(w_eff - WW'(2))))
		else $error("frame end flagged away from the last interior pixel");

	a_centre_bit_needs_zero_beta: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && code[4]) |-> (beta_q == '0))
		else $error("centre bit set with nonzero threshold");

endmodule
`default_nettype wire

FILE: rtl/bglbp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bglbp_front
// Accepts pixels, tracks row and column, keeps the two-line store and the
// window columns, and hands complete interior windows to the queue.
// ----------------------------------------------------------------------------
module bglbp_front #(
	parameter int MAX_WIDTH = bglbp_pkg::MAX_WIDTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic [$clog2(MAX_WIDTH+1)-1:0]     w_eff,
	input  wire logic [bglbp_pkg::ROW_W-1:0]        h_eff,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [bglbp_pkg::PIX_W-1:0]        pixel,
	output logic                                    q_valid,
	input  wire logic                               q_ready,
	output bglbp_pkg::item_t                        q_item,
	output logic                                    clearing
);
	import bglbp_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);

	logic [AW-1:0]        col_q;
	logic [ROW_W-1:0]     row_q;
	logic                 clr_busy_q;
	logic [AW-1:0]        clr_cnt_q;
	logic [2*PIX_W-1:0]   line_mem [MAX_WIDTH];
	logic [2*PIX_W-1:0]   rd_q;
	logic [PIX_W-1:0]     win_q [WIN][WIN-1];

	logic                 v_s1;
	logic                 emit_s1;
	logic                 last_s1;
	logic [PIX_W-1:0]     pix_s1;
	logic [AW-1:0]        col_s1;
	logic [ROW_W-1:0]     row_s1;

	logic                 wrap_col;
	logic [ROW_W-1:0]     row_a;
	logic [ROW_W-1:0]     row_c;
	logic [AW-1:0]        col_c;
	logic [WW-1:0]        col_n_ext;
	logic                 wrap_n;
	logic [AW-1:0]        col_n;
	logic [ROW_W-1:0]     row_n1;
	logic [ROW_W-1:0]     row_n;
	logic                 emit_c;
	logic                 last_c;
	logic                 acc;
	logic                 adv_s1;
	logic [AW-1:0]        col_m1;

	always_comb begin
		wrap_col  = WW'(col_q) >= w_eff;
		row_a     = wrap_col ? row_q + ROW_W'(1) : row_q;
		row_c     = (row_a >= h_eff) ? '0 : row_a;
		col_c     = wrap_col ? '0 : col_q;
		col_n_ext = WW'(col_c) + WW'(1);
		wrap_n    = col_n_ext >= w_eff;
		col_n     = wrap_n ? '0 : col_n_ext[AW-1:0];
		row_n1    = row_c + ROW_W'(1);
		if (wrap_n) begin
			row_n = (row_n1 >= h_eff) ? '0 : row_n1;
		end else begin
			row_n = row_c;
		end
		emit_c = (row_c >= ROW_W'(2)) && (col_c >= AW'(2));
		last_c = (row_c == h_eff - ROW_W'(1)) && (WW'(col_c) == w_eff - WW'(1));
	end

	assign adv_s1   = v_s1 && (!emit_s1 || q_ready);
	assign in_ready = !clr_busy_q && (!v_s1 || adv_s1);
	assign acc      = in_valid && in_ready;
	assign q_valid  = v_s1 && emit_s1;
	assign clearing = clr_busy_q;
	assign col_m1   = col_s1 - AW'(1);

	always_comb begin
		for (int r = 0; r < WIN; r++) begin
			for (int c = 0; c < WIN - 1; c++) begin
				q_item.pix[r*WIN + c] = win_q[r][c];
			end
		end
		q_item.pix[WIN - 1]       = rd_q[2*PIX_W-1:PIX_W];
		q_item.pix[2*WIN - 1]     = rd_q[PIX_W-1:0];
		q_item.pix[WIN_PIX - 1]   = pix_s1;
		q_item.row_index          = row_s1 - ROW_W'(1);
		q_item.col_index          = COL_W'(col_m1);
		q_item.last_of_frame      = last_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			v_s1       <= 1'b0;
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
			for (int r = 0; r < WIN; r++) begin
				for (int c = 0; c < WIN - 1; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else begin
			if (clr_busy_q) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
				if (clr_cnt_q == AW'(MAX_WIDTH - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (acc) begin
				col_q <= col_n;
				row_q <= row_n;
			end
			if (acc) begin
				v_s1 <= 1'b1;
			end else if (adv_s1) begin
				v_s1 <= 1'b0;
			end
			if (adv_s1) begin
				for (int r = 0; r < WIN; r++) begin
					win_q[r][0] <= win_q[r][1];
				end
				win_q[0][1] <= rd_q[2*PIX_W-1:PIX_W];
				win_q[1][1] <= rd_q[PIX_W-1:0];
				win_q[2][1] <= pix_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pix_s1  <= pixel;
			col_s1  <= col_c;
			row_s1  <= row_c;
			emit_s1 <= emit_c;
			last_s1 <= last_c;
		end
	end

	// line store entry: upper byte two rows back, lower byte previous row
	always_ff @(posedge clk) begin
		if (acc) begin
			rd_q <= line_mem[col_c];
		end
		if (clr_busy_q) begin
			line_mem[clr_cnt_q] <= '0;
		end else if (adv_s1) begin
			line_mem[col_s1] <= {rd_q[PIX_W-1:0], pix_s1};
		end
	end

endmodule
`default_nettype wire

FILE: rtl/bglbp_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bglbp_queue
// Short first-in first-out queue of window items between front and back.
// ----------------------------------------------------------------------------
module bglbp_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire bglbp_pkg::item_t  in_item,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output bglbp_pkg::item_t       out_item
);
	import bglbp_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	item_t          slot_q [QUEUE_DEPTH];
	logic [PW-1:0]  wr_q;
	logic [PW-1:0]  rd_q;
	logic [CW-1:0]  cnt_q;
	logic           push;
	logic           pop;

	assign in_ready  = cnt_q != CW'(QUEUE_DEPTH);
	assign out_valid = cnt_q != '0;
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_item  = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= in_item;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/bglbp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bglbp_back
// Three-stage code pipeline: row sums and nine-times pixels, deviations
// from the window sum, then the pair tests and the output register.
// ----------------------------------------------------------------------------
module bglbp_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [bglbp_pkg::BETA_W-1:0]  beta,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire bglbp_pkg::item_t              in_item,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [bglbp_pkg::PIX_W-1:0]        code,
	output logic [bglbp_pkg::ROW_W-1:0]        row_index,
	output logic [bglbp_pkg::COL_W-1:0]        col_index,
	output logic                               last_of_frame
);
	import bglbp_pkg::*;

	logic                        v_s1;
	logic                        v_s2;
	logic                        v_q;
	logic                        rdy_out;
	logic                        rdy_s2;
	logic                        rdy_s1;

	logic [ROWSUM_W-1:0]         rsum_s1 [WIN];
	logic [SUM_W-1:0]            nine_s1 [WIN_PIX];
	logic [ROW_W-1:0]            row_s1;
	logic [COL_W-1:0]            col_s1;
	logic                        last_s1;

	logic signed [DIFF_W-1:0]    dev_s2 [WIN_PIX];
	logic [ROW_W-1:0]            row_s2;
	logic [COL_W-1:0]            col_s2;
	logic                        last_s2;

	logic [SUM_W-1:0]            wsum;
	logic signed [DIFF_W-1:0]    dev_c [WIN_PIX];
	logic [DIFF_W-1:0]           lim;
	logic [PIX_W-1:0]            code_c;
	logic [SUM_W-1:0]            abs_a;
	logic [SUM_W-1:0]            abs_b;
	logic signed [DIFF_W-1:0]    da;
	logic signed [DIFF_W-1:0]    db;
	logic                        between;

	assign rdy_out   = !v_q || !out_stall;
	assign rdy_s2    = !v_s2 || rdy_out;
	assign rdy_s1    = !v_s1 || rdy_s2;
	assign in_ready  = rdy_s1;
	assign out_valid = v_q;

	always_comb begin
		wsum = SUM_W'(rsum_s1[0]) + SUM_W'(rsum_s1[1]) + SUM_W'(rsum_s1[2]);
		for (int k = 0; k < WIN_PIX; k++) begin
			dev_c[k] = $signed({1'b0, nine_s1[k]}) - $signed({1'b0, wsum});
		end
	end

	always_comb begin
		lim    = DIFF_W'({beta, 3'b000}) + DIFF_W'(beta);
		code_c = '0;
		abs_a  = '0;
		abs_b  = '0;
		da     = '0;
		db     = '0;
		between = 1'b0;
		for (int k = 0; k < PIX_W; k++) begin
			da      = dev_s2[k];
			db      = dev_s2[WIN_PIX-1-k];
			abs_a   = da[DIFF_W-1] ? SUM_W'(-da) : SUM_W'(da);
			abs_b   = db[DIFF_W-1] ? SUM_W'(-db) : SUM_W'(db);
			between = (!da[DIFF_W-1] && (db[DIFF_W-1] || db == '0)) ||
			          (da[DIFF_W-1] && !db[DIFF_W-1] && db != '0);
			code_c[k] = between && ((DIFF_W'(abs_a) + DIFF_W'(abs_b)) >= lim);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_q  <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= in_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_out) begin
				v_q <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			for (int r = 0; r < WIN; r++) begin
				rsum_s1[r] <= ROWSUM_W'(in_item.pix[r*WIN]) +
				              ROWSUM_W'(in_item.pix[r*WIN + 1]) +
				              ROWSUM_W'(in_item.pix[r*WIN + 2]);
			end
			for (int k = 0; k < WIN_PIX; k++) begin
				nine_s1[k] <= SUM_W'({in_item.pix[k], 3'b000}) + SUM_W'(in_item.pix[k]);
			end
			row_s1  <= in_item.row_index;
			col_s1  <= in_item.col_index;
			last_s1 <= in_item.last_of_frame;
		end
		if (rdy_s2) begin
			for (int k = 0; k < WIN_PIX; k++) begin
				dev_s2[k] <= dev_c[k];
			end
			row_s2  <= row_s1;
			col_s2  <= col_s1;
			last_s2 <= last_s1;
		end
		if (rdy_out) begin
			code          <= code_c;
			row_index     <= row_s2;
			col_index     <= col_s2;
			last_of_frame <= last_s2;
		end
	end

endmodule
`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// background_lbp_3x3_texture_code testbench
// Streams raster pixels through the texture coder and checks every code,
// row, column and frame-end flag against a cycle-free prediction of the
// 3x3 window. Image geometry and threshold are changed between phases,
// and both sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

	import bglbp_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS   = 1250;
	localparam int SETTLE_LIMIT   = 50000;
	localparam int SETTLE_PAD     = 16;
	localparam int HOLD_OFF       = 400;
	localparam int TIMEOUT_CYCLES = 600000;

	typedef struct {
		logic [PIX_W-1:0] code;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             frame_end;
	} lbp_result_t;

	typedef enum int {STYLE_UNIFORM, STYLE_NEAR_FLAT, STYLE_EXTREME} pixel_style_t;

	class lbp_scoreboard;
		bit [BETA_W-1:0]  beta;
		bit [IMG_W_W-1:0] width_reg;
		bit [IMG_H_W-1:0] height_reg;
		bit [PIX_W-1:0]   line_up1 [MAX_WIDTH_DEF];
		bit [PIX_W-1:0]   line_up2 [MAX_WIDTH_DEF];
		bit [PIX_W-1:0]   col_left2 [WIN];
		bit [PIX_W-1:0]   col_left1 [WIN];
		int unsigned      col_count;
		int unsigned      row_count;
		lbp_result_t      expected_codes [$];
		int               fail_count;
		int               checked_count;
		int               frame_ends;

		function new();
			beta = BETA_RST;
			width_reg = WIDTH_RST;
			height_reg = HEIGHT_RST;
			col_count = 0;
			row_count = 0;
			fail_count = 0;
			checked_count = 0;
			frame_ends = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
			case (idx)
				REG_BETA: beta = value[BETA_W-1:0];
				REG_WIDTH: width_reg = value[IMG_W_W-1:0];
				REG_HEIGHT: height_reg = value[IMG_H_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_pixel(bit [PIX_W-1:0] value);
			int unsigned w, h, c, r;
			int win [WIN_PIX];
			int s, lim, a, b, dev, i;
			bit [7:0] bits;
			lbp_result_t res;
			w = (width_reg < 3) ? 3 : (width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width_reg;
			h = (height_reg < 3) ? 3 : height_reg;
			if (col_count >= w) begin
				col_count = 0;
				row_count++;
			end
			if (row_count >= h)
				row_count = 0;
			c = col_count;
			r = row_count;
			for (i = 0; i < WIN; i++) begin
				win[i * 3] = col_left2[i];
				win[i * 3 + 1] = col_left1[i];
			end
			win[2] = line_up2[c];
			win[5] = line_up1[c];
			win[8] = value;
			if (r >= 2 && c >= 2) begin
				s = 0;
				for (i = 0; i < WIN_PIX; i++)
					s += win[i];
				lim = 9 * int'(beta);
				bits = '0;
				for (i = 0; i < 8; i++) begin
					a = 9 * win[i];
					b = 9 * win[8 - i];
					dev = ((a > s) ? a - s : s - a) + ((b > s) ? b - s : s - b);
					if (((a >= s && s >= b) || (a < s && s < b)) && dev >= lim)
						bits[i] = 1'b1;
				end
				res.code = bits;
				res.row = ROW_W'(r - 1);
				res.col = COL_W'(c - 1);
				res.frame_end = (r == h - 1 && c == w - 1);
				expected_codes.push_back(res);
			end
			line_up2[c] = line_up1[c];
			line_up1[c] = value;
			for (i = 0; i < WIN; i++) begin
				col_left2[i] = win[i * 3 + 1];
				col_left1[i] = win[i * 3 + 2];
			end
			col_count = c + 1;
			if (col_count >= w) begin
				col_count = 0;
				row_count = r + 1;
				if (row_count >= h)
					row_count = 0;
			end
		endfunction

		function void check_result(logic [PIX_W-1:0] got_code, logic [ROW_W-1:0] got_row,
				logic [COL_W-1:0] got_col, logic got_end);
			lbp_result_t want;
			if (expected_codes.size() == 0) begin
				$error("unexpected texture code %0d at row %0d col %0d", got_code, got_row,
					got_col);
				fail_count++;
				return;
			end
			want = expected_codes.pop_front();
			checked_count++;
			if (want.frame_end)
				frame_ends++;
			if (got_code !== want.code) begin
				$error("code: expected %0d, got %0d", want.code, got_code);
				fail_count++;
			end
			if (got_row !== want.row) begin
				$error("row_index: expected %0d, got %0d", want.row, got_row);
				fail_count++;
			end
			if (got_col !== want.col) begin
				$error("col_index: expected %0d, got %0d", want.col, got_col);
				fail_count++;
			end
			if (got_end !== want.frame_end) begin
				$error("last_of_frame: expected %0d, got %0d", want.frame_end, got_end);
				fail_count++;
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic [PIX_W-1:0]     pixel;
	logic                 out_valid;
	logic                 out_stall;
	logic [PIX_W-1:0]     code;
	logic [ROW_W-1:0]     row_index;
	logic [COL_W-1:0]     col_index;
	logic                 last_of_frame;

	lbp_scoreboard sb;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_request;
	int hold_left;
	int pixels_sent;
	int setting_writes;

	background_lbp_3x3_texture_code i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pixel(pixel),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.code(code),
		.row_index(row_index),
		.col_index(col_index),
		.last_of_frame(last_of_frame)
	);

	always #10 clk = ~clk;

	function automatic logic [PIX_W-1:0] pick_pixel(pixel_style_t style, logic [PIX_W-1:0] base);
		case (style)
			STYLE_UNIFORM: return PIX_W'($urandom_range(255));
			STYLE_NEAR_FLAT: return PIX_W'(base + $urandom_range(4) - 2);
			default: return $urandom_range(1) ? 8'hFF : 8'h00;
		endcase
	endfunction

	task automatic send_pixel(input logic [PIX_W-1:0] value);
		bit offered;
		offered = 1'b0;
		while (!offered) begin
			@(negedge clk);
			if ($urandom_range(99) < send_idle_pct)
				in_valid <= 1'b0;
			else begin
				in_valid <= 1'b1;
				pixel <= value;
				offered = 1'b1;
			end
		end
		do @(posedge clk); while (in_stall);
		sb.note_pixel(value);
		pixels_sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, value);
		setting_writes++;
	endtask

	task automatic settle();
		int guard;
		guard = 0;
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.expected_codes.size() != 0 && guard < SETTLE_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		if (sb.expected_codes.size() != 0) begin
			$error("%0d texture codes never arrived", sb.expected_codes.size());
			sb.fail_count++;
			sb.expected_codes.delete();
		end
		repeat (SETTLE_PAD) @(posedge clk);
	endtask

	task automatic apply_random_setting();
		logic [CFG_DATA_W-1:0] value;
		if ($urandom_range(99) < 60) begin
			case ($urandom_range(9))
				0: value = 12'd0;
				1: value = 12'd511;
				2: value = 12'($urandom_range(256, 511));
				3: value = 12'($urandom_range(0, 255));
				default: value = 12'($urandom_range(0, 24));
			endcase
			value[11:9] = 3'($urandom_range(7));
			write_reg(REG_BETA, value);
		end
		if ($urandom_range(99) < 50) begin
			case ($urandom_range(9))
				0: value = 12'($urandom_range(0, 2));
				1: value = 12'd3;
				2: value = 12'($urandom_range(1025, 2047));
				default: value = 12'($urandom_range(4, 12));
			endcase
			value[11] = 1'($urandom_range(1));
			write_reg(REG_WIDTH, value);
		end
		if ($urandom_range(99) < 40) begin
			case ($urandom_range(9))
				0: value = 12'($urandom_range(0, 2));
				1: value = 12'd3;
				2: value = 12'd4095;
				3: value = 12'($urandom_range(9, 4094));
				default: value = 12'($urandom_range(3, 8));
			endcase
			write_reg(REG_HEIGHT, value);
		end
		if ($urandom_range(99) < 5)
			write_reg(REG_UNUSED, 12'($urandom_range(4095)));
	endtask

	initial begin
		out_stall = 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				sb.check_result(code, row_index, col_index, last_of_frame);
			@(negedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else
				out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	initial begin
		repeat (TIMEOUT_CYCLES) @(posedge clk);
		$display("background_lbp_3x3_texture_code verification failed");
		$finish;
	end

	initial begin
		int random_items;
		int segment;
		int n;
		int i;
		bit wide_done;
		bit hold_done;
		pixel_style_t style;
		logic [PIX_W-1:0] base;

		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_BETA;
		cfg_data = '0;
		in_valid = 1'b0;
		pixel = '0;
		send_idle_pct = 34;
		recv_stall_pct = 81;
		hold_request = 0;
		pixels_sent = 0;
		setting_writes = 0;
		random_items = 0;
		wide_done = 1'b0;
		hold_done = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// smallest frame, zero threshold: a flat window sets every kept bit
		write_reg(REG_BETA, 12'd0);
		write_reg(REG_WIDTH, 12'd3);
		write_reg(REG_HEIGHT, 12'd3);
		repeat (9) send_pixel(8'hFF);
		for (i = 0; i < 9; i++)
			send_pixel((i == 4) ? 8'd128 : (i % 2 == 0) ? 8'h00 : 8'hFF);

		while (random_items < RANDOM_ITEMS) begin
			segment = random_items * 3 / RANDOM_ITEMS;
			send_idle_pct = (segment == 0) ? 34 : (segment == 1) ? 81 : 0;
			recv_stall_pct = (segment == 0) ? 81 : (segment == 1) ? 34 : 0;
			settle();
			if (segment == 1 && !wide_done) begin
				wide_done = 1'b1;
				write_reg(REG_BETA, 12'hFFF);
				write_reg(REG_WIDTH, 12'hFFF);
				write_reg(REG_HEIGHT, 12'd0);
				write_reg(REG_UNUSED, 12'($urandom_range(4095)));
				repeat (40) send_pixel(pick_pixel(STYLE_UNIFORM, 8'd0));
				settle();
				write_reg(REG_BETA, 12'($urandom_range(0, 12)));
				write_reg(REG_WIDTH, 12'd6);
				write_reg(REG_HEIGHT, 12'd4095);
				while (sb.row_count < 2)
					send_pixel(pick_pixel(STYLE_UNIFORM, 8'd0));
				settle();
			end
			apply_random_setting();
			n = $urandom_range(20, 120);
			if (segment == 2 && !hold_done) begin
				hold_done = 1'b1;
				write_reg(REG_WIDTH, 12'd5);
				write_reg(REG_HEIGHT, 12'd40);
				hold_request = HOLD_OFF;
				n = 200;
			end
			style = pixel_style_t'($urandom_range(2));
			base = PIX_W'($urandom_range(255));
			repeat (n) begin
				send_pixel(pick_pixel(style, base));
				random_items++;
			end
		end

		settle();
		$display("Sent %0d pixels over %0d register writes; checked %0d texture codes",
			pixels_sent, setting_writes, sb.checked_count);
		$display("Frames completed: %0d, mismatches: %0d", sb.frame_ends, sb.fail_count);
		if (sb.fail_count == 0)
			$display("background_lbp_3x3_texture_code verification clean");
		else
			$display("background_lbp_3x3_texture_code verification failed");
		$finish;
	end

endmodule
